@@ hw/rtl/sgcp_pkg.sv @@
// Shared types, constants and decode helpers for the Super I/O GPIO
// configuration port. Used by every module of the block; depends on nothing.
`default_nettype none

package sgcp_pkg;

  // Number of GPIO pins that exist (8 to 64); banks above them are unmapped.
  localparam int NUM_PINS   = 64;
  localparam int NUM_BANKS  = (NUM_PINS + 7) / 8;
  localparam int BANK_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int BANK_SLOTS = 1 << BANK_W;

  localparam logic [7:0]  KEY_ENTER     = 8'h87;
  localparam logic [7:0]  KEY_EXIT      = 8'hAA;
  localparam logic [15:0] CHIP_ID_RESET = 16'hC450;
  localparam logic [7:0]  IDX_LDSEL     = 8'h07;
  localparam logic [7:0]  IDX_ID_HI     = 8'h20;
  localparam logic [7:0]  IDX_ID_LO     = 8'h21;
  localparam logic [7:0]  IDX_ENABLE    = 8'h30;
  localparam logic [7:0]  IDX_DIR_BASE  = 8'hE0;
  localparam logic [7:0]  GPIO_DEVICE   = 8'h07;
  localparam logic [7:0]  LOCKED_READ   = 8'hFF;

  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 144;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DIR  = 2'd1,
    KIND_DATA = 2'd2
  } reg_kind_t;

  typedef struct packed {
    logic [63:0] pin_levels;
    logic [7:0]  write_data;
    logic        port_select;
    logic        action;
  } item_t;

  typedef struct packed {
    logic        config_unlocked_flag;
    logic [63:0] pin_output_enable;
    logic [63:0] pin_drive_values;
    logic [7:0]  read_data;
  } result_t;

  // Pins of bank b that exist.
  function automatic logic [7:0] bank_mask(input logic [2:0] b);
    int         n;
    logic [7:0] m;
    n = NUM_PINS - int'(b) * 8;
    if (n <= 0) begin
      m = '0;
    end else if (n >= 8) begin
      m = '1;
    end else begin
      m = 8'((1 << n) - 1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sgcp_in_stage.sv @@
// Input register of the GPIO configuration port: unpacks and holds one item.
// Depends on sgcp_pkg.
`default_nettype none

module sgcp_in_stage (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [sgcp_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [sgcp_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic                            take,
  output logic                                 item_valid,
  output sgcp_pkg::item_t                      item
);
  import sgcp_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action      <= in_tuser[0];
      item_r.port_select <= in_tuser[1];
      item_r.write_data  <= in_tdata[7:0];
      item_r.pin_levels  <= in_tdata[71:8];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

@@ hw/rtl/sgcp_core.sv @@
// Configuration state and access decode: key sequence, index register,
// device select, bank enables, direction and output latches. Uses sgcp_pkg.
`default_nettype none

module sgcp_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [15:0]      cfg_wr_data,
  input  wire logic             en,
  input  wire sgcp_pkg::item_t  item,
  output sgcp_pkg::result_t     result
);
  import sgcp_pkg::*;

  logic [15:0] chip_id_r;
  logic        key_seen_r, key_seen_nxt;
  logic        unlocked_r, unlocked_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  bank_en_r, bank_en_nxt;
  logic [7:0]  dir_r   [BANK_SLOTS];
  logic [7:0]  dir_nxt [BANK_SLOTS];
  logic [7:0]  latch_r   [BANK_SLOTS];
  logic [7:0]  latch_nxt [BANK_SLOTS];

  logic [7:0]        off;
  logic [BANK_W-1:0] bank;
  logic              bank_ok;
  reg_kind_t         kind;
  logic [7:0]        mask;
  logic [7:0]        lv;
  logic [7:0]        dir_sel;
  logic [7:0]        rd;
  logic [63:0]       drive;
  logic [63:0]       oe;

  always_comb begin
    off     = index_r - IDX_DIR_BASE;
    bank    = off[BANK_W+1:2];
    bank_ok = ({1'b0, off[4:2]} < 4'(NUM_BANKS));
    if (index_r >= IDX_DIR_BASE && !off[1] && bank_ok) begin
      kind = off[0] ? KIND_DATA : KIND_DIR;
    end else begin
      kind = KIND_NONE;
    end
    mask    = bank_mask(3'(bank));
    dir_sel = dir_r[bank];
    lv      = item.pin_levels[{bank, 3'b000} +: 8];

    key_seen_nxt = key_seen_r;
    unlocked_nxt = unlocked_r;
    index_nxt    = index_r;
    dev_nxt      = dev_r;
    bank_en_nxt  = bank_en_r;
    dir_nxt      = dir_r;
    latch_nxt    = latch_r;
    rd           = '0;

    if (en) begin
      if (!unlocked_r) begin
        if (item.action) begin
          rd = LOCKED_READ;
        end else if (!item.port_select) begin
          if (item.write_data == KEY_ENTER) begin
            // The second key byte in a row opens the configuration space.
            unlocked_nxt = key_seen_r;
            key_seen_nxt = !key_seen_r;
          end else begin
            key_seen_nxt = 1'b0;
          end
        end
      end else if (!item.port_select) begin
        if (item.action) begin
          rd = index_r;
        end else if (item.write_data == KEY_EXIT) begin
          unlocked_nxt = 1'b0;
          key_seen_nxt = 1'b0;
        end else begin
          index_nxt = item.write_data;
        end
      end else if (item.action) begin
        if (index_r == IDX_LDSEL) begin
          rd = dev_r;
        end else if (index_r == IDX_ID_HI) begin
          rd = chip_id_r[15:8];
        end else if (index_r == IDX_ID_LO) begin
          rd = chip_id_r[7:0];
        end else if (dev_r != GPIO_DEVICE) begin
          rd = '0;
        end else if (index_r == IDX_ENABLE) begin
          rd = bank_en_r;
        end else begin
          case (kind)
            KIND_DIR:  rd = dir_sel;
            KIND_DATA: rd = ((lv & dir_sel) | (latch_r[bank] & ~dir_sel)) & mask;
            default:   rd = '0;
          endcase
        end
      end else begin
        if (index_r == IDX_LDSEL) begin
          dev_nxt = item.write_data;
        end else if (dev_r == GPIO_DEVICE) begin
          if (index_r == IDX_ENABLE) begin
            bank_en_nxt = item.write_data;
          end else begin
            case (kind)
              KIND_DIR:  dir_nxt[bank]   = item.write_data | ~mask;
              KIND_DATA: latch_nxt[bank] = item.write_data & mask;
              default:   ;
            endcase
          end
        end
      end
    end

    // Pin views reflect the state left by this item.
    drive = '0;
    oe    = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      drive[b*8 +: 8] = latch_nxt[b] & bank_mask(3'(b));
      oe[b*8 +: 8]    = ~dir_nxt[b] & bank_mask(3'(b));
    end

    result.read_data            = rd;
    result.pin_drive_values     = drive;
    result.pin_output_enable    = oe;
    result.config_unlocked_flag = unlocked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_id_r  <= CHIP_ID_RESET;
      key_seen_r <= 1'b0;
      unlocked_r <= 1'b0;
      index_r    <= '0;
      dev_r      <= '0;
      bank_en_r  <= '1;
      for (int b = 0; b < BANK_SLOTS; b++) begin
        dir_r[b]   <= '1;
        latch_r[b] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        chip_id_r <= cfg_wr_data;
      end
      key_seen_r <= key_seen_nxt;
      unlocked_r <= unlocked_nxt;
      index_r    <= index_nxt;
      dev_r      <= dev_nxt;
      bank_en_r  <= bank_en_nxt;
      dir_r      <= dir_nxt;
      latch_r    <= latch_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_key_clear_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    !(key_seen_r && unlocked_r))
    else $error("key seen while configuration space is open");

  a_unlock_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(unlocked_r) |-> $past(key_seen_r && en))
    else $error("unlocked without a preceding key byte");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(unlocked_r) && $stable(index_r) && $stable(dev_r)))
    else $error("state changed with no item processed");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sgcp_out_stage.sv @@
// Output register of the GPIO configuration port: holds one result item and
// packs it onto the result channel. Depends on sgcp_pkg.
`default_nettype none

module sgcp_out_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             take,
  input  wire sgcp_pkg::result_t                result,
  output logic                                  room,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [sgcp_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import sgcp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign room      = !valid_r || out_tready;
  assign valid_nxt = take || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'b0, res_r.config_unlocked_flag, res_r.pin_output_enable,
                       res_r.pin_drive_values, res_r.read_data};

endmodule

`default_nettype wire

@@ hw/rtl/superio_gpio_config_port_unit.sv @@
// Top level of the Super I/O GPIO configuration port.
// Instantiates sgcp_in_stage, sgcp_core and sgcp_out_stage; uses sgcp_pkg.
//
// Each input item is one byte access to the index port or the data port of
// the configuration space. Two index writes of 0x87 open the space, 0xAA
// closes it. Every item yields exactly one result item carrying the read
// byte (zero on writes), the pin drive values, the pin output enables and
// the unlock flag as they stand after the access.
// The chip ID is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while no item is in flight, which the block does not enforce. It takes
// effect at the next clock edge. An accepted item is held in the input register
// until the core takes it; its result is then held in the output register,
// which raises out_tvalid.
// Throughput: one item per cycle while the receiver does not stall, set by the
// single decode pass between the two registers.
// Reset (rst_n low, synchronous) locks the space, clears the key, index and
// device select, sets bank enables to 0xFF, all pins to input and all output
// latches to zero; both registers are emptied.
// When the receiver stalls, the result is held; one more item is taken into
// the input register and in_tready then drops until the result leaves.
`default_nettype none

module superio_gpio_config_port_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // cfg_wr_data: chip_id[15:0]
  input  wire logic         cfg_wr_en,
  input  wire logic [15:0]  cfg_wr_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // in_tdata: write_data[7:0], pin_levels[71:8]
  input  wire logic [71:0]  in_tdata,
  // in_tuser: action[0], port_select[1]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_tdata: read_data[7:0], pin_drive_values[71:8], pin_output_enable[135:72],
  // config_unlocked_flag[136], zero fill[143:137]
  output logic [143:0]      out_tdata
);
  import sgcp_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  result_t result;
  logic    room;
  logic    take;

  assign take = s1_valid && room;

  sgcp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  sgcp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .en          (take),
    .item        (s1_item),
    .result      (result)
  );

  sgcp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .result     (result),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef ASSERT_OFF
  a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled although the result side can move");

  a_take_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_tvalid)
    else $error("processed item did not reach the output register");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !take) |=> s1_valid)
    else $error("waiting item dropped from the input register");
`endif

endmodule

`default_nettype wire
